FILE: sv/sparse_plane_nibble_store_top_defines.svh
// Assertion macros shared by the sparse plane nibble store RTL.
`ifndef SPARSE_PLANE_NIBBLE_STORE_TOP_DEFINES_SVH
`define SPARSE_PLANE_NIBBLE_STORE_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SPNS_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define SPNS_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/spns_pkg.sv
// Shared constants for the sparse plane nibble store.
`default_nettype none
package spns_pkg;

    localparam int NIB_W        = 4;
    localparam int COORD_W      = 4;
    localparam int LEVEL_W      = 7;
    localparam int COUNT_W      = 8;
    localparam int SPARSE_LIMIT = 127;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 16;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

endpackage
`default_nettype wire

FILE: sv/sparse_plane_nibble_store_top.sv
// Top level of the sparse plane nibble store: plane map, allocator and stream ports.
//
// Usage:
//   Slave stream carries one access per word: s_axis_tuser is the command
//   (0 read, 1 write), s_axis_tdata holds the cell coordinates and the nibble.
//   Master stream returns one result word per access: the nibble read (0 for
//   writes and for unallocated planes), the allocated plane count and a flag
//   set while fewer than 127 planes are in use.
//   Per access: accept, plane map lookup, a cell read for reads of allocated
//   planes only, then the result moves into the output register. The next
//   word is taken only after that: s_axis_tready rises again as m_axis_tvalid
//   does, so the block works on one access at a time.
//   After reset the cell memory is zeroed by a sweep over all LEVELS*PLANE_SIDE^2
//   entries (32768 at the defaults) and s_axis_tready stays low meanwhile.
//   Reset also marks every plane unallocated and clears the plane count.
//   When the receiver stalls, the finished result waits in the output
//   register while the next access is still taken and processed; it then
//   holds in the result stage until the output register frees.
`default_nettype none
`include "sparse_plane_nibble_store_top_defines.svh"
module sparse_plane_nibble_store_top #(
    parameter int LEVELS     = 128,
    parameter int PLANE_SIDE = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [3:0] col_x, [10:4] level_y, [14:11] col_z, [18:15] cell_value, [23:19] zero
    input  wire logic [spns_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] command
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [3:0] read_value, [11:4] planes_used, [12] is_sparse, [15:13] zero
    output logic      [spns_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int PLANE_CELLS = PLANE_SIDE * PLANE_SIDE;
    localparam int DEPTH       = LEVELS * PLANE_CELLS;
    localparam int AW          = $clog2(DEPTH);
    localparam int SW          = $clog2(LEVELS);
    localparam int UW          = $clog2(LEVELS + 1);
    localparam int NW          = spns_pkg::NIB_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_CELL,
        S_DONE
    } t_state;

    t_state r_state;

    // captured access
    logic                           r_cmd;
    logic [spns_pkg::COORD_W-1:0]   r_x;
    logic [spns_pkg::LEVEL_W-1:0]   r_y;
    logic [spns_pkg::COORD_W-1:0]   r_z;
    logic [NW-1:0]                  r_val;

    // plane map: slot memory plus per-level allocated flags
    logic [SW-1:0]                  r_map [LEVELS];
    logic [SW-1:0]                  r_map_q;
    logic [LEVELS-1:0]              r_valid;
    logic [UW-1:0]                  r_used;

    // pending result and output register
    logic [NW-1:0]                  r_res_rd;
    logic                           r_out_valid;
    logic [NW-1:0]                  r_out_rd;
    logic [spns_pkg::COUNT_W-1:0]   r_out_used;
    logic                           r_out_sparse;

    logic                           w_busy;
    logic [NW-1:0]                  w_cell_q;
    logic                           w_accept;
    logic                           w_out_free;
    logic [SW-1:0]                  w_lvl_idx;

    logic                           n_in_range;
    logic                           n_plane_valid;
    logic                           n_alloc;
    logic                           n_do_write;
    logic                           n_rd_hit;
    logic [SW-1:0]                  n_slot;
    logic [AW-1:0]                  n_addr;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_lvl_idx  = SW'(r_y);

    // map stage decode: range, allocation and cell address
    always_comb begin
        n_in_range    = (32'(r_y) < LEVELS) && (32'(r_x) < PLANE_SIDE)
                        && (32'(r_z) < PLANE_SIDE);
        n_plane_valid = r_valid[w_lvl_idx];
        n_alloc       = n_in_range && (r_cmd == spns_pkg::CMD_WRITE) && !n_plane_valid
                        && (r_val != '0) && (32'(r_used) < LEVELS);
        n_do_write    = n_in_range && (r_cmd == spns_pkg::CMD_WRITE)
                        && (n_plane_valid || n_alloc);
        n_rd_hit      = n_in_range && (r_cmd == spns_pkg::CMD_READ) && n_plane_valid;
        n_slot        = n_plane_valid ? r_map_q : SW'(r_used);
        n_addr        = AW'(n_slot) * AW'(PLANE_CELLS)
                        + AW'(r_x) * AW'(PLANE_SIDE) + AW'(r_z);
    end

    spns_cell_ram #(
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    ((r_state == S_MAP) && n_rd_hit),
        .i_we    ((r_state == S_MAP) && n_do_write),
        .i_addr  (n_addr),
        .i_wdata (r_val),
        .o_rdata (w_cell_q),
        .o_busy  (w_busy)
    );

    // slot memory: read on accept, written on allocation
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_map_q <= r_map[SW'(s_axis_tdata[10:4])];
        end
        if ((r_state == S_MAP) && n_alloc) begin
            r_map[w_lvl_idx] <= SW'(r_used);
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the sent word; the result stage reloads it on its own
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= s_axis_tuser;
                        r_x     <= s_axis_tdata[3:0];
                        r_y     <= s_axis_tdata[10:4];
                        r_z     <= s_axis_tdata[14:11];
                        r_val   <= s_axis_tdata[18:15];
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_res_rd <= '0;
                    if (n_alloc) begin
                        r_valid[w_lvl_idx] <= 1'b1;
                        r_used             <= r_used + 1'b1;
                    end
                    r_state <= n_rd_hit ? S_CELL : S_DONE;
                end
                S_CELL: begin
                    r_res_rd <= w_cell_q;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_rd     <= r_res_rd;
                        r_out_used   <= spns_pkg::COUNT_W'(r_used);
                        r_out_sparse <= (32'(r_used) < spns_pkg::SPARSE_LIMIT);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !w_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_sparse, r_out_used, r_out_rd};

    `SPNS_CHECK(a_count_matches_map, $countones(r_valid) == 32'(r_used), "plane count mismatch")
    `SPNS_CHECK(a_count_bounded, 32'(r_used) <= LEVELS, "plane count beyond level count")
    `SPNS_IMPLY(a_count_monotonic, $past(i_rst_n), r_used >= $past(r_used), "plane count fell")
    `SPNS_IMPLY(a_cell_after_map, r_state == S_CELL, $past(r_state) == S_MAP, "bad cell entry")
    `SPNS_IMPLY(a_no_access_in_sweep, w_busy, r_state == S_IDLE, "access during sweep")

endmodule
`default_nettype wire

FILE: sv/spns_cell_ram.sv
// Nibble cell memory with a zeroing sweep after reset.
`default_nettype none
module spns_cell_ram #(
    parameter  int DEPTH = 32768,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_re,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_addr,
    input  wire logic [spns_pkg::NIB_W-1:0] i_wdata,
    output logic      [spns_pkg::NIB_W-1:0] o_rdata,
    output logic                          o_busy
);

    logic [spns_pkg::NIB_W-1:0] r_mem [DEPTH];
    logic [spns_pkg::NIB_W-1:0] r_q;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_busy;

    // sweep one entry a cycle until the last one is zeroed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;
    assign o_busy  = r_busy;

endmodule
`default_nettype wire

FILE: sim/sparse_plane_nibble_store_top_tb.sv
// Self-checking stream testbench for the sparse plane nibble store top level.
`timescale 1ns / 1ps
module sparse_plane_nibble_store_top_tb;

    localparam int LEVELS      = 128;
    localparam int PLANE_SIDE  = 16;
    localparam int PLANE_CELLS = PLANE_SIDE * PLANE_SIDE;
    localparam int RANDOM_WORDS = 850;
    // Idle limit covers the cell memory clearing sweep after reset.
    localparam int IDLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                          cmd;
        logic [spns_pkg::COORD_W-1:0]  x;
        logic [spns_pkg::LEVEL_W-1:0]  y;
        logic [spns_pkg::COORD_W-1:0]  z;
        logic [spns_pkg::NIB_W-1:0]    val;
    } t_access;

    typedef struct packed {
        logic [spns_pkg::NIB_W-1:0]    read_value;
        logic [spns_pkg::COUNT_W-1:0]  planes_used;
        logic                          is_sparse;
    } t_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [3:0] col_x, [10:4] level_y, [14:11] col_z, [18:15] cell_value, [23:19] zero
    logic [spns_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // [0] command
    logic                    s_axis_tuser = spns_pkg::CMD_READ;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [3:0] read_value, [11:4] planes_used, [12] is_sparse, [15:13] zero
    logic [spns_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

    sparse_plane_nibble_store_top #(
        .LEVELS     (LEVELS),
        .PLANE_SIDE (PLANE_SIDE)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the store: plane map, slots, cells and plane count.
    // ------------------------------------------------------------------
    logic                         plane_alloc [LEVELS];
    int                           plane_slot  [LEVELS];
    logic [spns_pkg::NIB_W-1:0]   cell_store  [LEVELS * PLANE_CELLS];
    int                           planes_in_use = 0;

    t_access            access_queue [$];
    t_result            expected_results [$];
    int                 words_sent = 0;
    int                 words_total = 0;
    int                 mismatches = 0;

    initial begin
        for (int i = 0; i < LEVELS; i++) begin
            plane_alloc[i] = 1'b0;
            plane_slot[i]  = 0;
        end
        for (int i = 0; i < LEVELS * PLANE_CELLS; i++)
            cell_store[i] = '0;
    end

    // Apply one access to the shadow store and queue the result it must produce.
    function automatic void predict_access(t_access a);
        t_result r;
        int      cell_idx;
        int      lvl;
        cell_idx = int'(a.x) * PLANE_SIDE + int'(a.z);
        lvl      = int'(a.y);
        r.read_value = '0;
        if (a.cmd == spns_pkg::CMD_READ) begin
            if (plane_alloc[lvl])
                r.read_value = cell_store[plane_slot[lvl] * PLANE_CELLS + cell_idx];
        end else begin
            // Allocate on the first nonzero write; a zero write leaves an empty plane alone.
            if (!plane_alloc[lvl] && a.val != '0 && planes_in_use < LEVELS) begin
                plane_slot[lvl]  = planes_in_use;
                plane_alloc[lvl] = 1'b1;
                planes_in_use++;
            end
            if (plane_alloc[lvl])
                cell_store[plane_slot[lvl] * PLANE_CELLS + cell_idx] = a.val;
        end
        r.planes_used = planes_in_use[spns_pkg::COUNT_W-1:0];
        r.is_sparse   = (planes_in_use < spns_pkg::SPARSE_LIMIT);
        expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    task automatic add_access(logic cmd, int x, int y, int z, int val);
        t_access a;
        a.cmd = cmd;
        a.x   = x[spns_pkg::COORD_W-1:0];
        a.y   = y[spns_pkg::LEVEL_W-1:0];
        a.z   = z[spns_pkg::COORD_W-1:0];
        a.val = val[spns_pkg::NIB_W-1:0];
        access_queue.push_back(a);
    endtask

    t_access touched [$];
    int      fill_order [LEVELS];
    int      fill_next;

    task automatic build_stimulus();
        t_access a;
        int      r;
        int      j;
        int      tmp;

        // Directed: empty-plane reads, zero write to an empty plane, allocation,
        // fresh plane reads zero, corner coordinates and levels, read ignores value.
        add_access(spns_pkg::CMD_READ,   0,   0,  0, 0);
        add_access(spns_pkg::CMD_WRITE,  3,   5,  7, 0);
        add_access(spns_pkg::CMD_READ,   3,   5,  7, 0);
        add_access(spns_pkg::CMD_WRITE,  0,   0,  0, 15);
        add_access(spns_pkg::CMD_READ,   0,   0,  0, 0);
        add_access(spns_pkg::CMD_WRITE, 15, 127, 15, 1);
        add_access(spns_pkg::CMD_READ,  15, 127, 15, 0);
        add_access(spns_pkg::CMD_READ,  15, 127, 14, 0);
        add_access(spns_pkg::CMD_WRITE, 15, 127, 15, 0);
        add_access(spns_pkg::CMD_READ,  15, 127, 15, 0);
        add_access(spns_pkg::CMD_WRITE, 15,   0,  0, 10);
        add_access(spns_pkg::CMD_READ,  15,   0,  0, 0);
        add_access(spns_pkg::CMD_WRITE,  0,   0, 15, 5);
        add_access(spns_pkg::CMD_READ,   0,   0, 15, 15);
        add_access(spns_pkg::CMD_READ,   0,   0,  0, 15);
        add_access(spns_pkg::CMD_WRITE,  5, 85, 10, 10);
        add_access(spns_pkg::CMD_WRITE, 10, 42,  5, 5);
        add_access(spns_pkg::CMD_READ,   5, 85, 10, 0);
        add_access(spns_pkg::CMD_READ,  10, 42,  5, 0);
        add_access(spns_pkg::CMD_READ,  10, 42,  6, 0);
        add_access(spns_pkg::CMD_WRITE, 10, 42,  5, 0);
        add_access(spns_pkg::CMD_READ,  10, 42,  5, 0);

        // Shuffled allocation order so every level fills and the count crosses
        // the sparse threshold and reaches the full plane count.
        for (int i = 0; i < LEVELS; i++) fill_order[i] = i;
        for (int i = LEVELS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = fill_order[i];
            fill_order[i] = fill_order[j];
            fill_order[j] = tmp;
        end
        fill_next = 0;

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            r = $urandom_range(0, 99);
            a.x   = spns_pkg::COORD_W'($urandom_range(0, PLANE_SIDE - 1));
            a.z   = spns_pkg::COORD_W'($urandom_range(0, PLANE_SIDE - 1));
            a.y   = spns_pkg::LEVEL_W'($urandom_range(0, LEVELS - 1));
            a.val = spns_pkg::NIB_W'($urandom_range(0, 15));
            if (r < 25 && fill_next < LEVELS) begin
                a.cmd = spns_pkg::CMD_WRITE;
                a.y   = fill_order[fill_next][spns_pkg::LEVEL_W-1:0];
                a.val = spns_pkg::NIB_W'($urandom_range(1, 15));
                fill_next++;
            end else if (r < 45 && touched.size() > 0) begin
                tmp = $urandom_range(0, touched.size() - 1);
                a.cmd = spns_pkg::CMD_READ;
                a.x = touched[tmp].x;
                a.y = touched[tmp].y;
                a.z = touched[tmp].z;
            end else if (r < 60 && touched.size() > 0) begin
                tmp = $urandom_range(0, touched.size() - 1);
                a.cmd = spns_pkg::CMD_WRITE;
                a.x = touched[tmp].x;
                a.y = touched[tmp].y;
                a.z = touched[tmp].z;
            end else if (r < 78) begin
                a.cmd = spns_pkg::CMD_READ;
            end else begin
                a.cmd = spns_pkg::CMD_WRITE;
            end
            // Remember written cells so later reads come back to them.
            if (a.cmd == spns_pkg::CMD_WRITE) begin
                touched.push_back(a);
                if (touched.size() > 48) void'(touched.pop_front());
            end
            access_queue.push_back(a);
        end
        words_total = access_queue.size();
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps in between.
    // ------------------------------------------------------------------
    t_access cur_access;
    int      burst_left = 0;
    int      gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 16);
            gap_left   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_access(cur_access);
                words_sent++;
            end
            // Advance only when the bus is free; otherwise hold the word in flight.
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (access_queue.size() > 0) begin
                    cur_access = access_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, cur_access.val, cur_access.z,
                                      cur_access.y, cur_access.x};
                    s_axis_tuser  <= cur_access.cmd;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // Some bursts run back to back with no gap at all.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready pattern switches between always-ready, coin-flip and
    // long stalls.
    // ------------------------------------------------------------------
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_stall_left = 0;

    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(16, 120);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    rx_stall_left = $urandom_range(2, 20);
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word against the oldest expectation.
    // ------------------------------------------------------------------
    t_result got_result;
    t_result want_result;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result.read_value  = m_axis_tdata[3:0];
            got_result.planes_used = m_axis_tdata[11:4];
            got_result.is_sparse   = m_axis_tdata[12];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word %h at %0t", m_axis_tdata, $realtime);
            end else begin
                want_result = expected_results.pop_front();
                if (got_result !== want_result) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("ERROR: result mismatch at %0t: read_value exp %0d got %0d, ",
                               $realtime, want_result.read_value, got_result.read_value);
                        $display("planes_used exp %0d got %0d, is_sparse exp %0d got %0d",
                                 want_result.planes_used, got_result.planes_used,
                                 want_result.is_sparse, got_result.is_sparse);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either side for too long.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sparse_plane_nibble_store_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run control.
    // ------------------------------------------------------------------
    initial begin
        build_stimulus();
        @(posedge i_clk);
        while (!(words_sent == words_total && expected_results.size() == 0))
            @(posedge i_clk);
        // Let any stray trailing word show up at the monitor.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("sparse_plane_nibble_store_top test passed");
        else
            $display("sparse_plane_nibble_store_top test failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/spns_pkg.sv
sv/spns_cell_ram.sv
sv/sparse_plane_nibble_store_top.sv
sim/sparse_plane_nibble_store_top_tb.sv
